FILE: hdl/xalu_pkg.sv
package xalu_pkg;

  // Operation codes carried by req_type.
  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_ADC  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_SBB  = 5'd3;
  localparam logic [4:0] OP_AND  = 5'd4;
  localparam logic [4:0] OP_OR   = 5'd5;
  localparam logic [4:0] OP_XOR  = 5'd6;
  localparam logic [4:0] OP_SHL  = 5'd7;
  localparam logic [4:0] OP_SAL  = 5'd8;
  localparam logic [4:0] OP_SHR  = 5'd9;
  localparam logic [4:0] OP_SAR  = 5'd10;
  localparam logic [4:0] OP_MUL  = 5'd11;
  localparam logic [4:0] OP_IMUL = 5'd12;
  localparam logic [4:0] OP_DIV  = 5'd13;
  localparam logic [4:0] OP_IDIV = 5'd14;
  localparam logic [4:0] OP_MOD  = 5'd15;
  localparam logic [4:0] OP_IMOD = 5'd16;

  // Width codes: 8 << code bits.
  localparam logic [1:0] WC_8    = 2'd0;
  localparam logic [1:0] WC_16   = 2'd1;
  localparam logic [1:0] WC_32   = 2'd2;
  localparam logic [1:0] WC_64   = 2'd3;
  // Widest width outside division (a 32-bit machine word).
  localparam logic [1:0] WC_WORD = WC_32;

  // Bit positions in the stored flag vector.
  localparam int F_CF = 0;
  localparam int F_PF = 1;
  localparam int F_ZF = 2;
  localparam int F_SF = 3;
  localparam int F_OF = 4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [4:0]  op;
    logic [1:0]  wc;
    logic [63:0] a;
    logic [63:0] b;
  } xalu_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV
  } back_state_t;

  function automatic logic [63:0] width_mask(input logic [1:0] wc);
    logic [63:0] m;
    unique case (wc)
      WC_8:    m = 64'h0000_0000_0000_00FF;
      WC_16:   m = 64'h0000_0000_0000_FFFF;
      WC_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [63:0] v, input logic [1:0] wc);
    logic t;
    unique case (wc)
      WC_8:    t = v[7];
      WC_16:   t = v[15];
      WC_32:   t = v[31];
      default: t = v[63];
    endcase
    return t;
  endfunction

  function automatic logic [63:0] sign_widen(input logic [63:0] v, input logic [1:0] wc);
    logic [63:0] m;
    m = width_mask(wc);
    return top_bit(v, wc) ? (v | ~m) : (v & m);
  endfunction

  function automatic logic [6:0] width_bits(input logic [1:0] wc);
    return 7'd8 << wc;
  endfunction

endpackage

FILE: hdl/xalu_front.sv
module xalu_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [4:0]             in_req_type,
  input  logic [63:0]            in_src_operand,
  input  logic [63:0]            in_dest_operand,
  input  logic [1:0]             in_size_code,
  output logic                   q_valid,
  output xalu_pkg::xalu_item_t   q_item,
  input  logic                   q_take
);
  import xalu_pkg::*;

  xalu_item_t  qmem [QUEUE_DEPTH];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        is_div;
  logic [1:0]  wc;
  xalu_item_t  cls;

  // Division alone may run at 64 bits; all else is capped at the word width.
  always_comb begin
    is_div = (in_req_type == OP_DIV) || (in_req_type == OP_IDIV) ||
             (in_req_type == OP_MOD) || (in_req_type == OP_IMOD);
    wc = (!is_div && in_size_code == WC_64) ? WC_WORD : in_size_code;
    cls.op = in_req_type;
    cls.wc = wc;
    cls.a  = in_dest_operand & width_mask(wc);
    cls.b  = in_src_operand & width_mask(wc);
  end

  assign in_stall = (count_r == 2'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = qmem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_take ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: hdl/xalu_div.sv
module xalu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient,
  output logic [63:0] remainder
);
  import xalu_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh   = {rem_r, quo_r[63]};
    diff     = rem_sh - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = 64'd0;
      cnt_nxt  = 6'd63;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[64]) begin
        rem_nxt = diff[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: hdl/xalu_back.sv
module xalu_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  xalu_pkg::xalu_item_t   q_item,
  output logic                   q_take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [63:0]            out_result_value,
  output logic                   out_carry_flag,
  output logic                   out_parity_flag,
  output logic                   out_zero_flag,
  output logic                   out_sign_flag,
  output logic                   out_overflow_flag,
  output logic                   out_divide_error
);
  import xalu_pkg::*;

  back_state_t state_r, state_nxt;
  logic [4:0]  flags_r;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_res_r;
  logic        out_derr_r;
  xalu_item_t  cur_r;
  logic        na_r, nb_r;
  logic [63:0] prod_r;

  logic        out_free;
  logic        take;
  logic        h_mul, h_div, h_long;
  logic        h_na, h_nb;
  logic [63:0] h_m;
  logic [63:0] dvd, dvs;
  logic        div_busy;
  logic [63:0] div_quo, div_rem;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_full;

  logic [63:0] sc_res;
  logic [4:0]  sc_flags;
  logic        sc_derr;

  logic        load;
  logic [63:0] fin_res;
  logic [4:0]  fin_flags;
  logic        fin_derr;

  logic [64:0] sum, bb;
  logic [4:0]  n;
  logic [6:0]  w, sh_idx;
  logic [63:0] sa;
  logic [63:0] sb;
  logic        cf;
  logic [63:0] p_hi;
  logic [63:0] dq;

  function automatic logic [4:0] result_flags(input logic [4:0] f, input logic [63:0] res,
                                              input logic [1:0] wc);
    logic [4:0] g;
    g       = f;
    g[F_PF] = ~^res[7:0];
    g[F_ZF] = ((res & width_mask(wc)) == 64'd0);
    g[F_SF] = top_bit(res, wc);
    return g;
  endfunction

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    h_mul  = (q_item.op == OP_MUL) || (q_item.op == OP_IMUL);
    h_div  = (q_item.op == OP_DIV) || (q_item.op == OP_IDIV) ||
             (q_item.op == OP_MOD) || (q_item.op == OP_IMOD);
    h_long = h_mul || (h_div && q_item.b != 64'd0);
    h_m    = width_mask(q_item.wc);
    h_na   = ((q_item.op == OP_IDIV) || (q_item.op == OP_IMOD)) && top_bit(q_item.a, q_item.wc);
    h_nb   = ((q_item.op == OP_IDIV) || (q_item.op == OP_IMOD)) && top_bit(q_item.b, q_item.wc);
    dvd    = h_na ? (~sign_widen(q_item.a, q_item.wc) + 64'd1) : q_item.a;
    dvs    = h_nb ? (~sign_widen(q_item.b, q_item.wc) + 64'd1) : q_item.b;
  end

  assign take   = (state_r == S_IDLE) && q_valid && out_free;
  assign q_take = take;

  // Unsigned mul extends with zero, imul with the sign at the operand width.
  always_comb begin
    sa = sign_widen(q_item.a, q_item.wc);
    sb = sign_widen(q_item.b, q_item.wc);
    if (q_item.op == OP_IMUL) begin
      mul_a = $signed(sa[32:0]);
      mul_b = $signed(sb[32:0]);
    end else begin
      mul_a = $signed({1'b0, q_item.a[31:0]});
      mul_b = $signed({1'b0, q_item.b[31:0]});
    end
    prod_full = mul_a * mul_b;
  end

  xalu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (take && h_div && q_item.b != 64'd0),
    .dividend  (dvd),
    .divisor   (dvs),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Combinational results for the short operations on the queue head.
  always_comb begin
    sc_res   = 64'd0;
    sc_flags = flags_r;
    sc_derr  = 1'b0;
    sum      = {1'b0, q_item.a} + {1'b0, q_item.b} +
               {64'd0, (q_item.op == OP_ADC) && flags_r[F_CF]};
    bb       = {1'b0, q_item.b} + {64'd0, (q_item.op == OP_SBB) && flags_r[F_CF]};
    n        = q_item.b[4:0];
    w        = width_bits(q_item.wc);
    sh_idx   = w - {2'b00, n};
    cf       = 1'b0;
    case (q_item.op) inside
      OP_ADD, OP_ADC: begin
        sc_res         = sum[63:0] & h_m;
        sc_flags[F_CF] = sum[w];
        sc_flags[F_OF] = top_bit((q_item.a ^ sc_res) & (q_item.b ^ sc_res), q_item.wc);
        sc_flags       = result_flags(sc_flags, sc_res, q_item.wc);
      end
      OP_SUB, OP_SBB: begin
        sc_res         = (q_item.a - bb[63:0]) & h_m;
        sc_flags[F_CF] = ({1'b0, q_item.a} < bb);
        sc_flags[F_OF] = top_bit((q_item.a ^ q_item.b) & (q_item.a ^ sc_res), q_item.wc);
        sc_flags       = result_flags(sc_flags, sc_res, q_item.wc);
      end
      OP_AND, OP_OR, OP_XOR: begin
        if (q_item.op == OP_AND) begin
          sc_res = q_item.a & q_item.b;
        end else if (q_item.op == OP_OR) begin
          sc_res = q_item.a | q_item.b;
        end else begin
          sc_res = q_item.a ^ q_item.b;
        end
        sc_flags[F_CF] = 1'b0;
        sc_flags[F_OF] = 1'b0;
        sc_flags       = result_flags(sc_flags, sc_res, q_item.wc);
      end
      OP_SHL, OP_SAL, OP_SHR, OP_SAR: begin
        sc_res = q_item.a;
        if (n != 5'd0) begin
          if (q_item.op == OP_SHR) begin
            sc_res = q_item.a >> n;
            cf     = q_item.a[n - 5'd1];
            if (n == 5'd1) begin
              sc_flags[F_OF] = top_bit(q_item.a, q_item.wc);
            end
          end else if (q_item.op == OP_SAR) begin
            sc_res = 64'($signed(sa) >>> n) & h_m;
            cf     = sa[n - 5'd1];
            if (n == 5'd1) begin
              sc_flags[F_OF] = 1'b0;
            end
          end else begin
            sc_res = (q_item.a << n) & h_m;
            cf     = ({2'b00, n} <= w) ? q_item.a[sh_idx[5:0]] : 1'b0;
            if (n == 5'd1) begin
              sc_flags[F_OF] = top_bit(sc_res, q_item.wc) ^ cf;
            end
          end
          sc_flags[F_CF] = cf;
          sc_flags       = result_flags(sc_flags, sc_res, q_item.wc);
        end
      end
      OP_DIV, OP_IDIV, OP_MOD, OP_IMOD: begin
        // Only a zero divisor finishes here.
        sc_derr = 1'b1;
      end
      default: begin
        sc_res = 64'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take && h_long) begin
          state_nxt = h_mul ? S_MUL : S_DIV;
        end
      end
      S_MUL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (!div_busy && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    load      = 1'b0;
    fin_res   = 64'd0;
    fin_flags = flags_r;
    fin_derr  = 1'b0;
    p_hi      = prod_r >> width_bits(cur_r.wc);
    dq        = 64'd0;
    unique case (state_r)
      S_IDLE: begin
        if (take && !h_long) begin
          load      = 1'b1;
          fin_res   = sc_res;
          fin_flags = sc_flags;
          fin_derr  = sc_derr;
        end
      end
      S_MUL: begin
        load = out_free;
        if (cur_r.op == OP_IMUL) begin
          fin_res         = prod_r & width_mask(cur_r.wc + 2'd1);
          fin_flags[F_CF] = (sign_widen(prod_r, cur_r.wc) != prod_r);
        end else begin
          fin_res         = prod_r;
          fin_flags[F_CF] = (p_hi != 64'd0);
        end
        fin_flags[F_OF] = fin_flags[F_CF];
      end
      S_DIV: begin
        load = !div_busy && out_free;
        case (cur_r.op)
          OP_DIV:  dq = div_quo;
          OP_MOD:  dq = div_rem;
          OP_IDIV: dq = (na_r ^ nb_r) ? (~div_quo + 64'd1) : div_quo;
          default: dq = na_r ? (~div_rem + 64'd1) : div_rem;
        endcase
        fin_res = dq & width_mask(cur_r.wc);
      end
      default: load = 1'b0;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        flags_r <= fin_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= fin_res;
      out_derr_r <= fin_derr;
    end
    if (take) begin
      cur_r  <= q_item;
      na_r   <= h_na;
      nb_r   <= h_nb;
      prod_r <= prod_full[63:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_res_r;
  assign out_carry_flag    = flags_r[F_CF];
  assign out_parity_flag   = flags_r[F_PF];
  assign out_zero_flag     = flags_r[F_ZF];
  assign out_sign_flag     = flags_r[F_SF];
  assign out_overflow_flag = flags_r[F_OF];
  assign out_divide_error  = out_derr_r;

endmodule

FILE: hdl/x86_integer_alu_with_flags.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// in_      | in_valid / in_stall  | req_type, src_operand, dest_operand, size_code
// out_     | out_valid / out_stall| result_value, five flags, divide_error
//
// Add, logic, shift, unknown codes and a zero divisor are computed combinationally in
// the execute stage and registered at the output; mul and imul go through S_MUL (the
// product is registered). Division uses the restoring divider, one bit per cycle over
// 64 steps. Reset is synchronous and active low; it clears the queue, the flags and
// out_valid. A two-entry queue between decode and execute keeps accepting, until it
// is full, while execute or the output register is stalled.
module x86_integer_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_req_type,
  input  logic [63:0] in_src_operand,
  input  logic [63:0] in_dest_operand,
  input  logic [1:0]  in_size_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_value,
  output logic        out_carry_flag,
  output logic        out_parity_flag,
  output logic        out_zero_flag,
  output logic        out_sign_flag,
  output logic        out_overflow_flag,
  output logic        out_divide_error
);
  import xalu_pkg::*;

  logic       q_valid;
  logic       q_take;
  xalu_item_t q_item;

  xalu_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_src_operand  (in_src_operand),
    .in_dest_operand (in_dest_operand),
    .in_size_code    (in_size_code),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_take          (q_take)
  );

  xalu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_take            (q_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_carry_flag    (out_carry_flag),
    .out_parity_flag   (out_parity_flag),
    .out_zero_flag     (out_zero_flag),
    .out_sign_flag     (out_sign_flag),
    .out_overflow_flag (out_overflow_flag),
    .out_divide_error  (out_divide_error)
  );

endmodule
